@@ src/tun_pkg.sv @@
// Shared widths, types and constants for the triangle unit normal pipeline.
package tun_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int NORMAL_FRAC = 15;
    localparam int OUT_WIDTH   = 16;

    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int HALF_W  = MAG_W / 2;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QBITS   = NORMAL_FRAC + 1;

    localparam int NORM_MAX_I = (((1 << NORMAL_FRAC) - 1) > 32767) ? 32767
                                : ((1 << NORMAL_FRAC) - 1);
    localparam logic [QBITS:0] NORM_MAX = (QBITS + 1)'(NORM_MAX_I);

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
        logic       last;
    } tag_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        tag_t                  tag;
    } side_t;

endpackage

@@ src/triangle_unit_normal.sv @@
// Triangle unit normal: edges, cross product, integer square root, scaling divide.
// Pipeline: six front stages, one stage per root bit, a divide load stage, one stage per
// quotient bit, output register.
// Throughput: one item per cycle; the whole pipeline holds when the output is stalled.
// Reset clears only the valid bits; data registers are not reset.
module triangle_unit_normal
    import tun_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by_coord,
    input  logic signed [COORD_WIDTH-1:0] bz,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] cz,
    input  logic                          last_face,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_WIDTH-1:0]   norm_x,
    output logic signed [OUT_WIDTH-1:0]   norm_y,
    output logic signed [OUT_WIDTH-1:0]   norm_z,
    output logic                          degenerate,
    output logic                          last_out
);

    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1: edges
    logic                     v1_reg;
    logic                     l1_reg;
    logic signed [EDGE_W-1:0] eux_reg, euy_reg, euz_reg, evx_reg, evy_reg, evz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_reg  <= last_face;
            eux_reg <= {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
            euy_reg <= {by_coord[COORD_WIDTH-1], by_coord} - {ay[COORD_WIDTH-1], ay};
            euz_reg <= {bz[COORD_WIDTH-1], bz} - {az[COORD_WIDTH-1], az};
            evx_reg <= {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
            evy_reg <= {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};
            evz_reg <= {cz[COORD_WIDTH-1], cz} - {az[COORD_WIDTH-1], az};
        end
    end

    // stage 2: edge products
    logic                     v2_reg;
    logic                     l2_reg;
    logic signed [PROD_W-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l2_reg   <= l1_reg;
            p_yz_reg <= euy_reg * evz_reg;
            p_zy_reg <= euz_reg * evy_reg;
            p_zx_reg <= euz_reg * evx_reg;
            p_xz_reg <= eux_reg * evz_reg;
            p_xy_reg <= eux_reg * evy_reg;
            p_yx_reg <= euy_reg * evx_reg;
        end
    end

    // stage 3: cross product as sign and magnitude
    logic signed [CROSS_W-1:0] cr [3];
    logic        [CROSS_W-1:0] cr_abs [3];
    logic                      v3_reg;
    logic                      l3_reg;
    logic        [MAG_W-1:0]   m3_reg [3];
    logic        [2:0]         n3_reg;

    assign cr[0] = {p_yz_reg[PROD_W-1], p_yz_reg} - {p_zy_reg[PROD_W-1], p_zy_reg};
    assign cr[1] = {p_zx_reg[PROD_W-1], p_zx_reg} - {p_xz_reg[PROD_W-1], p_xz_reg};
    assign cr[2] = {p_xy_reg[PROD_W-1], p_xy_reg} - {p_yx_reg[PROD_W-1], p_yx_reg};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cr_abs[i] = cr[i][CROSS_W-1] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l3_reg <= l2_reg;
            for (int i = 0; i < 3; i++)
            begin
                m3_reg[i] <= cr_abs[i][MAG_W-1:0];
                n3_reg[i] <= cr[i][CROSS_W-1];
            end
        end
    end

    // stage 4: partial products of the squares
    logic               v4_reg;
    side_t              s4_reg;
    logic [MAG_W-1:0]   hh_reg [3];
    logic [MAG_W-1:0]   hl_reg [3];
    logic [MAG_W-1:0]   ll_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg.tag.neg   <= n3_reg;
            s4_reg.tag.degen <= 1'b0;
            s4_reg.tag.last  <= l3_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_reg.mag[i] <= m3_reg[i];
                hh_reg[i] <= m3_reg[i][MAG_W-1:HALF_W] * m3_reg[i][MAG_W-1:HALF_W];
                hl_reg[i] <= m3_reg[i][MAG_W-1:HALF_W] * m3_reg[i][HALF_W-1:0];
                ll_reg[i] <= m3_reg[i][HALF_W-1:0] * m3_reg[i][HALF_W-1:0];
            end
        end
    end

    // stage 5: squares
    logic             v5_reg;
    side_t            s5_reg;
    logic [SQ_W-1:0]  sq5_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_reg <= s4_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i] <= (SQ_W'(hh_reg[i]) << MAG_W)
                            + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                            + SQ_W'(ll_reg[i]);
            end
        end
    end

    // stage 6: squared length, enters root stage 0
    logic [SUM_W-1:0] sum_next;
    logic             sv_reg    [ROOT_W+1];
    side_t            sside_reg [ROOT_W+1];
    logic [SUM_W-1:0] rad_reg   [ROOT_W+1];
    logic [REM_W-1:0] srem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg [ROOT_W+1];

    assign sum_next = sq5_reg[0] + sq5_reg[1] + sq5_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sside_reg[0].mag       <= s5_reg.mag;
            sside_reg[0].tag.neg   <= s5_reg.tag.neg;
            sside_reg[0].tag.degen <= (sum_next == '0);
            sside_reg[0].tag.last  <= s5_reg.tag.last;
            rad_reg[0]             <= sum_next;
            srem_reg[0]            <= '0;
            root_reg[0]            <= '0;
        end
    end

    // square root, one root bit per stage
    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_sqrt
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        logic             take;

        assign cur   = {srem_reg[k-1], rad_reg[k-1][SUM_W-1 -: 2]};
        assign trial = (REM_W + 2)'({root_reg[k-1], 2'b01});
        assign take  = (cur >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sside_reg[k] <= sside_reg[k-1];
                rad_reg[k]   <= rad_reg[k-1] << 2;
                srem_reg[k]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
                root_reg[k]  <= {root_reg[k-1][ROOT_W-2:0], take};
            end
        end
    end

    // divide stage 0 takes the root
    logic              dv_reg   [QBITS+1];
    tag_t              dtag_reg [QBITS+1];
    logic [ROOT_W-1:0] dlen_reg [QBITS+1];
    logic [ROOT_W-1:0] drem_reg [QBITS+1][3];
    logic [QBITS-1:0]  dq_reg   [QBITS+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= sv_reg[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dtag_reg[0] <= sside_reg[ROOT_W].tag;
            dlen_reg[0] <= root_reg[ROOT_W];
            for (int i = 0; i < 3; i++)
            begin
                drem_reg[0][i] <= sside_reg[ROOT_W].mag[i];
                dq_reg[0][i]   <= '0;
            end
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 1; j <= QBITS; j++)
    begin : g_div
        logic [ROOT_W:0] cand [3];
        logic [2:0]      take;

        for (genvar i = 0; i < 3; i++)
        begin : g_comp
            if (j == 1)
            begin : g_first
                assign cand[i] = {1'b0, drem_reg[j-1][i]};
            end
            else
            begin : g_rest
                assign cand[i] = {drem_reg[j-1][i], 1'b0};
            end
            assign take[i] = (cand[i] >= {1'b0, dlen_reg[j-1]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_reg[j] <= dv_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dtag_reg[j] <= dtag_reg[j-1];
                dlen_reg[j] <= dlen_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[j][i] <= take[i] ? ROOT_W'(cand[i] - {1'b0, dlen_reg[j-1]})
                                              : ROOT_W'(cand[i]);
                    dq_reg[j][i]   <= {dq_reg[j-1][i][QBITS-2:0], take[i]};
                end
            end
        end
    end

    // round, saturate, sign; a degenerate face gives zero
    logic [QBITS:0]         qr   [3];
    logic [QBITS:0]         qs   [3];
    logic [OUT_WIDTH-1:0]   nres [3];
    logic [OUT_WIDTH-1:0]   nx_reg, ny_reg, nz_reg;
    logic                   dg_reg;
    logic                   lo_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qr[i] = {1'b0, dq_reg[QBITS][i]}
                  + (QBITS + 1)'({drem_reg[QBITS][i], 1'b0} >= {1'b0, dlen_reg[QBITS]});
            qs[i] = (qr[i] > NORM_MAX) ? NORM_MAX : qr[i];
            if (dtag_reg[QBITS].degen)
            begin
                nres[i] = '0;
            end
            else if (dtag_reg[QBITS].neg[i])
            begin
                nres[i] = OUT_WIDTH'(-qs[i]);
            end
            else
            begin
                nres[i] = OUT_WIDTH'(qs[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= nres[0];
            ny_reg <= nres[1];
            nz_reg <= nres[2];
            dg_reg <= dtag_reg[QBITS].degen;
            lo_reg <= dtag_reg[QBITS].last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign norm_x     = nx_reg;
    assign norm_y     = ny_reg;
    assign norm_z     = nz_reg;
    assign degenerate = dg_reg;
    assign last_out   = lo_reg;

endmodule

@@ sim/tb.sv @@
// Testbench for triangle_unit_normal: random and directed triangles checked against a local normal predictor.
`timescale 1ns / 1ps
module tb;
    import tun_pkg::*;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic last;
    } tri_t;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] nx, ny, nz;
        logic degen, last;
    } norm_t;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz;
    logic last_face;
    logic signed [OUT_WIDTH-1:0] norm_x, norm_y, norm_z;
    logic degenerate, last_out;

    tri_t  tri_q[$];
    norm_t normal_q[$];
    int    errors = 0;
    int    results_seen = 0;
    int    cycles = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    hold_left = 0;
    bit    hold_done = 0;
    bit    in_fire = 0;
    bit    out_fire = 0;

    triangle_unit_normal uut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] scale_comp(logic [147:0] mag, logic neg,
                                               logic [147:0] len);
        logic [147:0] num, q, rem;
        num = mag << NORMAL_FRAC;
        q = num / len;
        rem = num % len;
        if ((rem << 1) >= len)
            q = q + 1;
        if (q > NORM_MAX_I)
            q = NORM_MAX_I;
        return neg ? 16'(-q) : 16'(q);
    endfunction

    function automatic norm_t face_normal(tri_t t);
        logic signed [33:0] ux, uy, uz, vx, vy, vz;
        logic signed [71:0] nx, ny, nz;
        logic [147:0] mx, my, mz, s, r, c;
        norm_t res;
        ux = 34'(t.bx) - 34'(t.ax);
        uy = 34'(t.by) - 34'(t.ay);
        uz = 34'(t.bz) - 34'(t.az);
        vx = 34'(t.cx) - 34'(t.ax);
        vy = 34'(t.cy) - 34'(t.ay);
        vz = 34'(t.cz) - 34'(t.az);
        nx = 72'(uy) * 72'(vz) - 72'(uz) * 72'(vy);
        ny = 72'(uz) * 72'(vx) - 72'(ux) * 72'(vz);
        nz = 72'(ux) * 72'(vy) - 72'(uy) * 72'(vx);
        mx = {76'b0, (nx < 0) ? -nx : nx};
        my = {76'b0, (ny < 0) ? -ny : ny};
        mz = {76'b0, (nz < 0) ? -nz : nz};
        s = mx * mx + my * my + mz * mz;
        res.last = t.last;
        if (s == 0)
        begin
            res.nx = 0; res.ny = 0; res.nz = 0; res.degen = 1;
            return res;
        end
        r = 0;
        for (int b = 73; b >= 0; b--)
        begin
            c = r | (148'(1) << b);
            if (c * c <= s)
                r = c;
        end
        res.nx = scale_comp(mx, nx < 0, r);
        res.ny = scale_comp(my, ny < 0, r);
        res.nz = scale_comp(mz, nz < 0, r);
        res.degen = 0;
        return res;
    endfunction

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 131072)) - 65536);
            2: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    task automatic add_tri(logic [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, logic l);
        tri_t t;
        t.ax = a0; t.ay = a1; t.az = a2;
        t.bx = b0; t.by = b1; t.bz = b2;
        t.cx = c0; t.cy = c1; t.cz = c2;
        t.last = l;
        tri_q.push_back(t);
    endtask

    initial
    begin
        int mode;
        logic [31:0] k, p, q;
        rst_n = 0;
        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(5, 6, 7, 5, 6, 7, 5, 6, 7, 1);
        add_tri(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0, 0);
        add_tri(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0, 1);
        add_tri(0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0);
        add_tri(0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0);
        add_tri(0, 0, 0, 1, 2, 3, 2, 4, 6, 0);
        add_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 1);
        add_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 0);
        add_tri(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1);
        add_tri(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1, 1, 1, 0);
        add_tri(0, 0, 0, 32'h7fffffff, 1, 0, 1, 32'h7fffffff, 0, 0);
        add_tri(0, 0, 0, 1, 1, 0, 1, 0, 1, 0);
        add_tri(0, 0, 0, 32'hffff0000, 0, 0, 0, 32'hffff0000, 0, 1);
        add_tri(0, 0, 0, 3, 0, 0, 0, 4, 5, 0);
        for (int i = 0; i < 1450; i++)
        begin
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
            begin
                k = rnd_coord(3); p = rnd_coord(mode); q = rnd_coord(mode);
                add_tri(p, q, k, p + k, q + k, k + k, p - k, q - k, 0, $urandom_range(0, 1));
            end
            else
                add_tri(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                        rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                        rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
                        $urandom_range(0, 1));
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (tri_q.size() == 0 && !in_valid);
        wait (normal_q.size() == 0);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("** triangle_unit_normal: PASSED **");
        else
            $display("** triangle_unit_normal: FAILED **");
        $finish;
    end

    initial
    begin
        in_valid = 0; out_ready = 0; last_face = 0;
        ax = 0; ay = 0; az = 0; bx = 0; by_coord = 0; bz = 0; cx = 0; cy = 0; cz = 0;
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (in_fire || !in_valid))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 0;
                send_gap <= send_gap - 1;
            end
            else if (tri_q.size() > 0)
            begin
                tri_t t;
                t = tri_q.pop_front();
                ax <= t.ax; ay <= t.ay; az <= t.az;
                bx <= t.bx; by_coord <= t.by; bz <= t.bz;
                cx <= t.cx; cy <= t.cy; cz <= t.cz;
                last_face <= t.last;
                in_valid <= 1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            end
            else
                in_valid <= 0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= 300)
            begin
                hold_done <= 1;
                hold_left <= 300;
                out_ready <= 0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 0;
            end
            else if (out_fire || !out_ready)
            begin
                if (recv_gap > 0)
                begin
                    recv_gap <= recv_gap - 1;
                    out_ready <= 0;
                end
                else
                begin
                    out_ready <= 1;
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        tri_t t;
        norm_t e;
        cycles <= cycles + 1;
        if (cycles > 300000)
        begin
            $display("** triangle_unit_normal: FAILED **");
            $finish;
        end
        in_fire <= in_valid && in_ready;
        out_fire <= out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
        begin
            t.ax = ax; t.ay = ay; t.az = az;
            t.bx = bx; t.by = by_coord; t.bz = bz;
            t.cx = cx; t.cy = cy; t.cz = cz;
            t.last = last_face;
            normal_q.push_back(face_normal(t));
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (normal_q.size() == 0)
            begin
                $error("unexpected result item");
                errors++;
            end
            else
            begin
                e = normal_q.pop_front();
                if (norm_x !== e.nx)
                begin
                    $error("norm_x expected %0d got %0d", e.nx, norm_x); errors++;
                end
                if (norm_y !== e.ny)
                begin
                    $error("norm_y expected %0d got %0d", e.ny, norm_y); errors++;
                end
                if (norm_z !== e.nz)
                begin
                    $error("norm_z expected %0d got %0d", e.nz, norm_z); errors++;
                end
                if (degenerate !== e.degen)
                begin
                    $error("degenerate expected %0b got %0b", e.degen, degenerate); errors++;
                end
                if (last_out !== e.last)
                begin
                    $error("last_out expected %0b got %0b", e.last, last_out); errors++;
                end
            end
        end
    end

endmodule
